// File: src/nfsm_pkg.sv
// Package for the NCO frequency shift mixer: shared constants, register codes,
// the pipeline advance struct and the elaboration-time sine table function.
// No dependencies.
`default_nettype none

package nfsm_pkg;

    // Default parameter values for the top level.
    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    // Fixed field widths.
    localparam int INC_BITS       = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int ROM_BITS       = 16;
    localparam int FRAC_BITS      = 15;

    // Table generation constants: pi/2 in Q30 and the Q1.15 full scale.
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ROM_SCALE   = 64'sd32767;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PHASE_INC    = 2'd0,
        REG_KEEP_PHASE   = 2'd1,
        REG_COMPLEX_MODE = 2'd2
    } cfg_reg_t;

    // Per-stage advance enables of the four-stage pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } adv_t;

    // Truncating quotient of two non-negative values by shift and subtract.
    // Used only while the table is built at elaboration.
    function automatic longint quotient(input longint num, input longint den);
        longint rem;
        longint quo;
        rem = 0;
        quo = 0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            quo = quo <<< 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'sd1;
            end
        end
        return quo;
    endfunction

    // Sine over the first quadrant, k of quarter steps, Q30 Taylor series,
    // scaled to 32767 and rounded. Evaluated at elaboration only.
    function automatic longint quadrant_sine(input longint k, input int addr_bits);
        longint x;
        longint x2;
        longint term;
        longint sum;
        x    = (HALF_PI_Q30 * k) >>> (addr_bits - 2);
        x2   = (x * x) >>> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 6; n++)
        begin
            term = quotient((term * x2) >>> 30, longint'((2 * n) * (2 * n + 1)));
            if ((n & 1) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        if (sum < 0)
            sum = 0;
        return (sum * ROM_SCALE + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // Full-turn table entry built from the quadrant by quarter-wave symmetry.
    function automatic logic signed [ROM_BITS-1:0] sine_entry(input int k,
                                                              input int addr_bits);
        int     quarter;
        int     q;
        int     r;
        longint s;
        quarter = 1 << (addr_bits - 2);
        q       = k >> (addr_bits - 2);
        r       = k & (quarter - 1);
        if ((q & 1) != 0)
            s = quadrant_sine(longint'(quarter - r), addr_bits);
        else
            s = quadrant_sine(longint'(r), addr_bits);
        if ((q & 2) != 0)
            s = -s;
        return ROM_BITS'(s);
    endfunction

endpackage

`default_nettype wire

// File: src/nfsm_phase.sv
// Phase accumulator of the NCO and table address generation.
// Depends on nfsm_pkg.
`default_nettype none

module nfsm_phase #(
    parameter int PHASE_BITS      = nfsm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = nfsm_pkg::TABLE_ADDR_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          block_start,
    input  wire logic                          keep_phase,
    input  wire logic [nfsm_pkg::INC_BITS-1:0] phase_increment,
    output logic      [TABLE_ADDR_BITS-1:0]    table_addr
);

    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [PHASE_BITS-1:0] phase_cur;

    // A block start restarts the phase at zero unless the phase is kept.
    always_comb
    begin
        phase_cur      = (block_start && !keep_phase) ? '0 : phase_acc_reg;
        phase_acc_next = phase_cur + PHASE_BITS'(phase_increment);
    end

    // The table is addressed by the top bits of the phase.
    assign table_addr = phase_cur[PHASE_BITS-1 -: TABLE_ADDR_BITS];

    // Advance once per accepted beat; wraps modulo a full turn.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_acc_reg <= '0;
        else if (accept)
            phase_acc_reg <= phase_acc_next;
    end

endmodule

`default_nettype wire

// File: src/nfsm_sine_rom.sv
// Sine table ROM with two registered read ports: sine at the address and
// cosine a quarter turn later. Depends on nfsm_pkg.
`default_nettype none

module nfsm_sine_rom #(
    parameter int TABLE_ADDR_BITS = nfsm_pkg::TABLE_ADDR_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 en,
    input  wire logic        [TABLE_ADDR_BITS-1:0]    addr,
    output logic signed      [nfsm_pkg::ROM_BITS-1:0] sine,
    output logic signed      [nfsm_pkg::ROM_BITS-1:0] cosine
);

    localparam int TABLE_SIZE = 1 << TABLE_ADDR_BITS;
    localparam logic [TABLE_ADDR_BITS-1:0] QUARTER =
        TABLE_ADDR_BITS'(1) << (TABLE_ADDR_BITS - 2);

    logic signed [nfsm_pkg::ROM_BITS-1:0] rom [TABLE_SIZE];
    logic        [TABLE_ADDR_BITS-1:0]    cos_addr;
    logic signed [nfsm_pkg::ROM_BITS-1:0] sine_reg;
    logic signed [nfsm_pkg::ROM_BITS-1:0] cosine_reg;

    // Table contents are fixed at elaboration.
    for (genvar k = 0; k < TABLE_SIZE; k++)
    begin : g_rom
        localparam logic signed [nfsm_pkg::ROM_BITS-1:0] ENTRY =
            nfsm_pkg::sine_entry(k, TABLE_ADDR_BITS);
        assign rom[k] = ENTRY;
    end

    // Cosine address wraps around the table naturally.
    assign cos_addr = addr + QUARTER;

    // Registered reads.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg   <= rom[addr];
            cosine_reg <= rom[cos_addr];
        end
    end

    assign sine   = sine_reg;
    assign cosine = cosine_reg;

endmodule

`default_nettype wire

// File: src/nfsm_mixer.sv
// Complex multiplier with rounding and saturation: a product stage followed
// by the sum, round and saturate stage that feeds the result registers.
// Depends on nfsm_pkg.
`default_nettype none

module nfsm_mixer #(
    parameter int SAMPLE_BITS = nfsm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                    clk,
    input  wire nfsm_pkg::adv_t                          adv,
    input  wire logic                                    complex_mode,
    input  wire logic signed    [SAMPLE_BITS-1:0]        si,
    input  wire logic signed    [SAMPLE_BITS-1:0]        sq,
    input  wire logic signed    [nfsm_pkg::ROM_BITS-1:0] sine,
    input  wire logic signed    [nfsm_pkg::ROM_BITS-1:0] cosine,
    output logic signed         [SAMPLE_BITS-1:0]        out_i,
    output logic signed         [SAMPLE_BITS-1:0]        out_q
);

    localparam int PROD_BITS = SAMPLE_BITS + nfsm_pkg::ROM_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int RND_BITS  = SUM_BITS - nfsm_pkg::FRAC_BITS;
    localparam logic signed [SUM_BITS-1:0] ROUND_HALF =
        SUM_BITS'(1) <<< (nfsm_pkg::FRAC_BITS - 1);

    logic signed [PROD_BITS-1:0]   prod_ic_reg;
    logic signed [PROD_BITS-1:0]   prod_qs_reg;
    logic signed [PROD_BITS-1:0]   prod_is_reg;
    logic signed [PROD_BITS-1:0]   prod_qc_reg;
    logic signed [PROD_BITS-1:0]   prod_ic_next;
    logic signed [PROD_BITS-1:0]   prod_qs_next;
    logic signed [PROD_BITS-1:0]   prod_is_next;
    logic signed [PROD_BITS-1:0]   prod_qc_next;
    logic signed [SUM_BITS-1:0]    sum_i;
    logic signed [SUM_BITS-1:0]    sum_q;
    logic signed [SUM_BITS-1:0]    biased_i;
    logic signed [SUM_BITS-1:0]    biased_q;
    logic signed [RND_BITS-1:0]    rnd_i;
    logic signed [RND_BITS-1:0]    rnd_q;
    logic signed [SAMPLE_BITS-1:0] out_i_reg;
    logic signed [SAMPLE_BITS-1:0] out_q_reg;
    logic signed [SAMPLE_BITS-1:0] out_i_next;
    logic signed [SAMPLE_BITS-1:0] out_q_next;

    // Clamp a rounded value to the signed sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] saturate(
        input logic signed [RND_BITS-1:0] v
    );
        logic [RND_BITS-SAMPLE_BITS:0] top;
        top = v[RND_BITS-1:SAMPLE_BITS-1];
        if ((&top) || !(|top))
            return v[SAMPLE_BITS-1:0];
        else if (v[RND_BITS-1])
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    // The four sample-by-phasor products.
    always_comb
    begin
        prod_ic_next = PROD_BITS'(si) * PROD_BITS'(cosine);
        prod_qs_next = PROD_BITS'(sq) * PROD_BITS'(sine);
        prod_is_next = PROD_BITS'(si) * PROD_BITS'(sine);
        prod_qc_next = PROD_BITS'(sq) * PROD_BITS'(cosine);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            prod_ic_reg <= prod_ic_next;
            prod_qs_reg <= prod_qs_next;
            prod_is_reg <= prod_is_next;
            prod_qc_reg <= prod_qc_next;
        end
    end

    // Combine, round half up, drop the fraction and saturate.
    always_comb
    begin
        if (complex_mode)
        begin
            sum_i = SUM_BITS'(prod_ic_reg) - SUM_BITS'(prod_qs_reg);
            sum_q = SUM_BITS'(prod_is_reg) + SUM_BITS'(prod_qc_reg);
        end
        else
        begin
            sum_i = SUM_BITS'(prod_is_reg);
            sum_q = '0;
        end
        biased_i   = sum_i + ROUND_HALF;
        biased_q   = sum_q + ROUND_HALF;
        rnd_i      = $signed(biased_i[SUM_BITS-1:nfsm_pkg::FRAC_BITS]);
        rnd_q      = $signed(biased_q[SUM_BITS-1:nfsm_pkg::FRAC_BITS]);
        out_i_next = saturate(rnd_i);
        out_q_next = saturate(rnd_q);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            out_i_reg <= out_i_next;
            out_q_reg <= out_q_next;
        end
    end

    assign out_i = out_i_reg;
    assign out_q = out_q_reg;

endmodule

`default_nettype wire

// File: src/nco_frequency_shift_mixer.sv
// NCO frequency shift mixer top level: configuration registers, pipeline
// control and the phase, table and mixer stages.
// Depends on nfsm_pkg, nfsm_phase, nfsm_sine_rom and nfsm_mixer.
//
// Shifts a stream of I/Q samples in frequency by mixing with a numerically
// controlled oscillator. One beat is accepted per clock cycle while the
// input is not stalled; each result passes through these stages in order:
// phase and table address, registered sine/cosine table read, the four
// products, and the sum/round/saturate step into the result registers.
// Result channel back pressure stalls a full stage only if all later ones are
// full too; empty stages keep filling. In complex mode the result is the sample
// rotated by cos + j*sin, in real mode out_i is sample_i * sin and out_q is
// zero. block_start restarts the phase at zero unless keep_phase is set.
// Write configuration only while no beats are in flight.
`default_nettype none

module nco_frequency_shift_mixer #(
    parameter int PHASE_BITS      = nfsm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = nfsm_pkg::TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = nfsm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Sample channel
    input  wire logic                                sample_valid,
    output logic                                     sample_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample_i,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample_q,
    input  wire logic                                block_start,
    // Result channel
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output logic signed      [SAMPLE_BITS-1:0]       out_i,
    output logic signed      [SAMPLE_BITS-1:0]       out_q,
    // Configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [nfsm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [nfsm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    logic [nfsm_pkg::INC_BITS-1:0]        phase_increment_reg;
    logic                                 keep_phase_reg;
    logic                                 complex_mode_reg;
    logic [3:0]                           valid_reg;
    logic [3:0]                           valid_next;
    nfsm_pkg::adv_t                       adv;
    logic                                 accept;
    logic [TABLE_ADDR_BITS-1:0]           table_addr;
    logic [TABLE_ADDR_BITS-1:0]           addr_reg;
    logic signed [SAMPLE_BITS-1:0]        s1_i_reg;
    logic signed [SAMPLE_BITS-1:0]        s1_q_reg;
    logic signed [SAMPLE_BITS-1:0]        s2_i_reg;
    logic signed [SAMPLE_BITS-1:0]        s2_q_reg;
    logic signed [nfsm_pkg::ROM_BITS-1:0] sine;
    logic signed [nfsm_pkg::ROM_BITS-1:0] cosine;

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_increment_reg <= '0;
            keep_phase_reg      <= 1'b0;
            complex_mode_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nfsm_pkg::REG_PHASE_INC:
                    phase_increment_reg <= cfg_data[nfsm_pkg::INC_BITS-1:0];
                nfsm_pkg::REG_KEEP_PHASE:
                    keep_phase_reg <= cfg_data[0];
                nfsm_pkg::REG_COMPLEX_MODE:
                    complex_mode_reg <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    always_comb
    begin
        adv.s4 = !valid_reg[3] || result_ready;
        adv.s3 = !valid_reg[2] || adv.s4;
        adv.s2 = !valid_reg[1] || adv.s3;
        adv.s1 = !valid_reg[0] || adv.s2;
    end

    assign sample_ready = adv.s1;
    assign accept       = sample_valid && adv.s1;
    assign result_valid = valid_reg[3];

    // Stage valid bits.
    always_comb
    begin
        valid_next[0] = adv.s1 ? sample_valid : valid_reg[0];
        valid_next[1] = adv.s2 ? valid_reg[0] : valid_reg[1];
        valid_next[2] = adv.s3 ? valid_reg[1] : valid_reg[2];
        valid_next[3] = adv.s4 ? valid_reg[2] : valid_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Phase accumulator and table address.
    nfsm_phase #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_phase (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .block_start     (block_start),
        .keep_phase      (keep_phase_reg),
        .phase_increment (phase_increment_reg),
        .table_addr      (table_addr)
    );

    // Input register and sample alignment with the table read.
    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            addr_reg <= table_addr;
            s1_i_reg <= sample_i;
            s1_q_reg <= sample_q;
        end
        if (adv.s2)
        begin
            s2_i_reg <= s1_i_reg;
            s2_q_reg <= s1_q_reg;
        end
    end

    // Sine and cosine lookup.
    nfsm_sine_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .clk    (clk),
        .en     (adv.s2),
        .addr   (addr_reg),
        .sine   (sine),
        .cosine (cosine)
    );

    // Products, rounding and saturation into the result registers.
    nfsm_mixer #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mixer (
        .clk          (clk),
        .adv          (adv),
        .complex_mode (complex_mode_reg),
        .si           (s2_i_reg),
        .sq           (s2_q_reg),
        .sine         (sine),
        .cosine       (cosine),
        .out_i        (out_i),
        .out_q        (out_q)
    );

`ifndef SYNTHESIS
    // A block start without keep_phase addresses the table at phase zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && block_start && !keep_phase_reg
        |-> table_addr == '0)
        else $error("block start did not restart the phase");

    // Real mode never produces a quadrature result.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !complex_mode_reg |-> out_q == '0)
        else $error("nonzero out_q in real mode");

    // With the output kept ready, an accepted beat goes through every stage and shows result_valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready ##1 result_ready ##1 result_ready
        ##1 result_ready |=> result_valid)
        else $error("beat lost in the pipeline");
`endif

endmodule

`default_nettype wire

// File: bench/tb_nco_frequency_shift_mixer.sv
// Self-checking testbench for the NCO frequency shift mixer: directed and random sample
// streams across register settings, checked beat by beat against a local phase/sine predictor.
// Depends on nfsm_pkg and nco_frequency_shift_mixer.
module tb_nco_frequency_shift_mixer;
    timeunit 1ns;
    timeprecision 1ps;

    import nfsm_pkg::*;

    localparam int SMP_W          = SAMPLE_BITS_DEF;
    localparam int PH_W           = PHASE_BITS_DEF;
    localparam int TAB_BITS       = TABLE_ADDR_BITS_DEF;
    localparam int TAB_SIZE       = 1 << TAB_BITS;
    localparam int QUARTER_TURN   = TAB_SIZE / 4;
    localparam int SMP_MAX        = (1 << (SMP_W - 1)) - 1;
    localparam int SMP_MIN        = -(1 << (SMP_W - 1));
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic signed [SMP_W-1:0] i;
        logic signed [SMP_W-1:0] q;
        logic                    start;
    } sample_beat_t;

    typedef struct {
        logic signed [SMP_W-1:0] i;
        logic signed [SMP_W-1:0] q;
    } mixed_iq_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                           sample_valid = 1'b0;
    logic                           sample_ready;
    logic signed [SMP_W-1:0]        sample_i = '0;
    logic signed [SMP_W-1:0]        sample_q = '0;
    logic                           block_start = 1'b0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    logic signed [SMP_W-1:0]        out_i;
    logic signed [SMP_W-1:0]        out_q;
    logic                           cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0]      cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]       cfg_data = '0;

    // Local copy of the oscillator state and register settings.
    int                   sine_tab [TAB_SIZE];
    logic [PH_W-1:0]      nco_phase = '0;
    logic [INC_BITS-1:0]  phase_step = '0;
    logic                 hold_phase = 1'b0;
    logic                 rotate_mode = 1'b1;

    sample_beat_t pending_samples [$];
    mixed_iq_t    mixed_expect [$];
    int           queued_beats = 0;
    int           accepted_beats = 0;
    int           errors = 0;

    // Pacing controls, changed only between phases.
    bit           fast_sender = 1'b0;
    bit           fast_receiver = 1'b0;
    bit           long_hold_req = 1'b0;

    nco_frequency_shift_mixer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_i     (sample_i),
        .sample_q     (sample_q),
        .block_start  (block_start),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_i        (out_i),
        .out_q        (out_q),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // First-quadrant sine in Q30 by Taylor series, scaled to full scale and rounded.
    function automatic int quadrant_amplitude(input int k);
        longint x;
        longint x2;
        longint term;
        longint acc;
        x    = (64'sd1686629713 * longint'(k)) / QUARTER_TURN;
        x2   = (x * x) >>> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >>> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        if (acc < 0)
            acc = 0;
        return int'((acc * 32767 + (64'sd1 <<< 29)) >>> 30);
    endfunction

    // Round half up, drop the fraction bits and clamp to the sample range.
    function automatic logic signed [SMP_W-1:0] round_clamp(input longint v);
        longint r;
        r = (v + 16384) >>> FRAC_BITS;
        if (r > SMP_MAX)
            r = SMP_MAX;
        if (r < SMP_MIN)
            r = SMP_MIN;
        return SMP_W'(r);
    endfunction

    // Mix one sample with the oscillator and advance the phase.
    function automatic mixed_iq_t mix_with_nco(input sample_beat_t s);
        mixed_iq_t       r;
        logic [PH_W-1:0] ph;
        int              idx;
        longint          sn;
        longint          cs;
        ph = (s.start && !hold_phase) ? '0 : nco_phase;
        idx = int'(ph[PH_W-1 -: TAB_BITS]);
        sn = sine_tab[idx];
        cs = sine_tab[(idx + QUARTER_TURN) % TAB_SIZE];
        if (rotate_mode)
        begin
            r.i = round_clamp(longint'(s.i) * cs - longint'(s.q) * sn);
            r.q = round_clamp(longint'(s.i) * sn + longint'(s.q) * cs);
        end
        else
        begin
            r.i = round_clamp(longint'(s.i) * sn);
            r.q = '0;
        end
        nco_phase = ph + PH_W'(phase_step);
        return r;
    endfunction

    // Sample driver: loads the next beat once the previous one is taken.
    int   send_wait = 0;
    logic send_next;
    sample_beat_t send_beat;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (sample_valid && sample_ready)
            begin
                send_beat.i = sample_i;
                send_beat.q = sample_q;
                send_beat.start = block_start;
                mixed_expect.push_back(mix_with_nco(send_beat));
                accepted_beats++;
                send_wait = fast_sender ? 0 : $urandom_range(0, 15);
            end
            if (!sample_valid || sample_ready)
            begin
                send_next = 1'b0;
                if (send_wait > 0)
                    send_wait--;
                else if (pending_samples.size() > 0)
                begin
                    send_beat = pending_samples.pop_front();
                    sample_i <= send_beat.i;
                    sample_q <= send_beat.q;
                    block_start <= send_beat.start;
                    send_next = 1'b1;
                end
                sample_valid <= send_next;
            end
        end
    end

    // Result monitor: checks each beat and paces result_ready.
    int        recv_wait = 0;
    int        hold_left = 0;
    bit        hold_taken = 1'b0;
    logic      recv_next;
    mixed_iq_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (mixed_expect.size() == 0)
                begin
                    $display("%0t: result beat with none expected: i=%0d q=%0d",
                             $time, out_i, out_q);
                    errors++;
                end
                else
                begin
                    want = mixed_expect.pop_front();
                    if (out_i !== want.i)
                    begin
                        $display("%0t: out_i mismatch: expected %0d, actual %0d",
                                 $time, want.i, out_i);
                        errors++;
                    end
                    if (out_q !== want.q)
                    begin
                        $display("%0t: out_q mismatch: expected %0d, actual %0d",
                                 $time, want.q, out_q);
                        errors++;
                    end
                end
                recv_wait = fast_receiver ? 0 : $urandom_range(0, 15);
            end
            if (long_hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = LONG_HOLD;
            end
            recv_next = 1'b0;
            if (hold_left > 0)
                hold_left--;
            else if (recv_wait > 0)
                recv_wait--;
            else
                recv_next = 1'b1;
            result_ready <= recv_next;
        end
    end

    // Watchdog on cycles with no beat on either channel.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_sample(input int i, input int q, input bit start);
        sample_beat_t b;
        b.i = SMP_W'(i);
        b.q = SMP_W'(q);
        b.start = start;
        pending_samples.push_back(b);
        queued_beats++;
    endtask

    // One register write; the local copy follows since the block is idle.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_PHASE_INC:    phase_step = value;
            REG_KEEP_PHASE:   hold_phase = value[0];
            REG_COMPLEX_MODE: rotate_mode = value[0];
            default:          ;
        endcase
    endtask

    // Single-bit registers get junk in the unused upper bits.
    function automatic logic [31:0] flag_word(input bit flag);
        return {$urandom} & 32'hFFFF_FFFE | 32'(flag);
    endfunction

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every queued beat is mixed and checked, then let the pipeline settle.
    task automatic drain_pipeline();
        while (accepted_beats != queued_beats || mixed_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int edge_sample();
        case ($urandom_range(0, 7))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return 0;
            default: return int'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h0000_0001;
            4:       return $urandom_range(1, 1 << 22);
            default: return $urandom;
        endcase
    endfunction

    // Stimulus sequence.
    int blk_len;
    int left;

    initial
    begin
        for (int k = 0; k < TAB_SIZE; k++)
        begin
            if ((k / QUARTER_TURN) % 2 == 1)
                sine_tab[k] = quadrant_amplitude(QUARTER_TURN - k % QUARTER_TURN);
            else
                sine_tab[k] = quadrant_amplitude(k % QUARTER_TURN);
            if ((k / QUARTER_TURN) >= 2)
                sine_tab[k] = -sine_tab[k];
        end
        fast_sender = $urandom_range(0, 1);
        fast_receiver = $urandom_range(0, 1);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero step, complex rotation at phase zero.
        push_sample(SMP_MAX, SMP_MAX, 1'b1);
        push_sample(SMP_MIN, SMP_MIN, 1'b0);
        push_sample(SMP_MIN, SMP_MAX, 1'b0);
        push_sample(0, -1, 1'b0);
        drain_pipeline();

        // Eighth-turn steps with full-scale samples drive the sums into saturation.
        write_reg(REG_PHASE_INC, 32'h2000_0000);
        write_reg(REG_KEEP_PHASE, flag_word(1'b0));
        write_reg(REG_COMPLEX_MODE, flag_word(1'b1));
        end_writes();
        for (int n = 0; n < 8; n++)
        begin
            case (n % 4)
                0:       push_sample(SMP_MIN, SMP_MIN, n == 0);
                1:       push_sample(SMP_MAX, SMP_MAX, 1'b0);
                2:       push_sample(SMP_MAX, SMP_MIN, 1'b0);
                default: push_sample(SMP_MIN, SMP_MAX, 1'b0);
            endcase
        end
        drain_pipeline();

        // Real mode, largest step so the phase wraps each sample, phase kept at block starts.
        write_reg(REG_COMPLEX_MODE, flag_word(1'b0));
        write_reg(REG_PHASE_INC, 32'hFFFF_FFFF);
        write_reg(REG_KEEP_PHASE, flag_word(1'b1));
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        end_writes();
        push_sample(SMP_MAX, SMP_MIN, 1'b0);
        push_sample(SMP_MIN, 12345, 1'b1);
        push_sample(SMP_MIN, 0, 1'b0);
        push_sample(1, -1, 1'b0);
        push_sample(-1, 1, 1'b1);
        push_sample(SMP_MAX, SMP_MAX, 1'b0);
        drain_pipeline();

        // Quarter-turn step with block starts in mid-stream restarting the phase.
        write_reg(REG_KEEP_PHASE, flag_word(1'b0));
        write_reg(REG_PHASE_INC, 32'h4000_0000);
        end_writes();
        push_sample(SMP_MAX, 0, 1'b0);
        push_sample(SMP_MAX, 0, 1'b0);
        push_sample(SMP_MIN, 0, 1'b1);
        push_sample(SMP_MIN, 5, 1'b0);
        push_sample(SMP_MAX, 0, 1'b0);
        push_sample(SMP_MIN, SMP_MIN, 1'b1);
        drain_pipeline();

        // Random phases: new settings each time, streams made of sample blocks.
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(REG_PHASE_INC, pick_step());
            write_reg(REG_KEEP_PHASE, flag_word($urandom_range(0, 1)));
            write_reg(REG_COMPLEX_MODE, flag_word($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, $urandom);
            end_writes();
            fast_sender = ($urandom_range(0, 2) == 0);
            fast_receiver = ($urandom_range(0, 2) == 0);
            if (ph == 2)
            begin
                // Receiver stalls long while the sender keeps offering beats.
                fast_sender = 1'b1;
                long_hold_req = 1'b1;
            end
            left = 155;
            while (left > 0)
            begin
                blk_len = $urandom_range(1, 40);
                if (blk_len > left)
                    blk_len = left;
                for (int n = 0; n < blk_len; n++)
                begin
                    // Mostly well-formed blocks; now and then a missing or stray marker.
                    if ($urandom_range(0, 9) == 0)
                        push_sample(edge_sample(), edge_sample(), $urandom_range(0, 1));
                    else
                        push_sample(edge_sample(), edge_sample(), n == 0);
                end
                left -= blk_len;
            end
            drain_pipeline();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
src/nfsm_pkg.sv
src/nfsm_phase.sv
src/nfsm_sine_rom.sv
src/nfsm_mixer.sv
src/nco_frequency_shift_mixer.sv
bench/tb_nco_frequency_shift_mixer.sv
